>>> rtl/core/fbpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_pkg: shared types and constants of the block pool allocator
// Transfer structs, request and status codes, register indexes and the
// pool size clamp used by the datapath.
// ----------------------------------------------------------------------------
package fbpa_pkg;

	localparam int POOL_DEPTH_DEF = 256;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 32;

	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_PUT = 1'b1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_OOM   = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_RANGE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WORDS  = 2'd2;

	localparam logic [8:0]  NUM_BLOCKS_RST   = 9'd256;
	localparam logic [31:0] BASE_ADDRESS_RST = 32'd0;
	localparam logic [14:0] BLOCK_WORDS_RST  = 15'd1;

	typedef struct packed {
		logic       req_type;
		logic [7:0] ret_index;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  got_index;
		logic [31:0] got_address;
		logic [8:0]  free_left;
	} rsp_t;

	typedef struct packed {
		logic accept;
		logic pop;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic get_ok;
	} sts_t;

	// pool size limited to 1..lim
	function automatic logic [8:0] clamp_size(logic [8:0] nb, int lim);
		logic [8:0] n;
		n = nb;
		if (n == 9'd0) begin
			n = 9'd1;
		end
		if (n > 9'(lim)) begin
			n = 9'(lim);
		end
		return n;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/fbpa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_ctrl: allocator controller
// Handshake control, pop sequencing and the pending and output slot
// valid flags.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire fbpa_pkg::sts_t sts,
	output fbpa_pkg::cmd_t      cmd
);
	import fbpa_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_POP  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   pend_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free     = !out_valid_q || out_ready;
	assign in_ready     = (state_q == ST_IDLE) && (!pend_q || out_free);
	assign out_valid    = out_valid_q;
	assign cmd.accept   = in_valid && in_ready;
	assign cmd.pop      = (state_q == ST_POP);
	assign cmd.load_out = pend_q && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.accept && sts.get_ok) begin
					state_d = ST_POP;
				end
			end
			ST_POP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				pend_q <= 1'b1;
			end else if (cmd.load_out) begin
				pend_q <= 1'b0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/fbpa_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_dp: allocator datapath
// Config registers, free list head and count, link memory with per-entry
// valid bits, address computation and the result registers.
// ----------------------------------------------------------------------------
module fbpa_dp #(
	parameter int POOL_DEPTH = fbpa_pkg::POOL_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire fbpa_pkg::req_t                  in_data,
	output fbpa_pkg::rsp_t                       out_data,
	input  wire logic                            cfg_we,
	input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire fbpa_pkg::cmd_t                  cmd,
	output fbpa_pkg::sts_t                       sts
);
	import fbpa_pkg::*;

	localparam int LIM = (POOL_DEPTH < 256) ? POOL_DEPTH : 256;
	localparam int AW  = $clog2(LIM);

	logic [8:0]    num_blocks_q;
	logic [31:0]   base_address_q;
	logic [14:0]   block_words_q;
	logic [7:0]    head_q;
	logic [8:0]    count_q;
	logic [LIM-1:0] vld_q;
	logic [7:0]    link_mem [LIM];
	logic [7:0]    link_rd_q;
	rsp_t          pend_q;
	rsp_t          out_q;

	logic          cfg_hit;
	logic [8:0]    nb_next;
	logic [8:0]    n_cur;
	logic [14:0]   words;
	logic [22:0]   prod;
	logic [31:0]   addr;
	logic [AW-1:0] head_a;
	logic [AW-1:0] ridx_a;
	logic          put_ok;
	logic          put_full;
	logic          put_range;
	rsp_t          rsp;

	always_comb begin
		cfg_hit = 1'b0;
		nb_next = num_blocks_q;
		unique case (cfg_index)
			CFG_NUM_BLOCKS: begin
				cfg_hit = cfg_we;
				nb_next = cfg_wdata[8:0];
			end
			CFG_BASE_ADDRESS: cfg_hit = cfg_we;
			CFG_BLOCK_WORDS:  cfg_hit = cfg_we;
			default:          cfg_hit = 1'b0;
		endcase
	end

	assign n_cur  = clamp_size(num_blocks_q, LIM);
	assign words  = (block_words_q == 15'd0) ? 15'd1 : block_words_q;
	assign prod   = 23'(head_q) * 23'(words);
	assign addr   = base_address_q + 32'({prod, 2'b00});
	assign head_a = head_q[AW-1:0];
	assign ridx_a = in_data.ret_index[AW-1:0];

	assign sts.get_ok = (in_data.req_type == REQ_GET) && (count_q != 9'd0);
	assign put_range  = (9'(in_data.ret_index) >= n_cur);
	assign put_full   = !put_range && (count_q >= n_cur);
	assign put_ok     = (in_data.req_type == REQ_PUT) && !put_range && !put_full;

	always_comb begin
		rsp = '0;
		if (in_data.req_type == REQ_GET) begin
			if (count_q == 9'd0) begin
				rsp.status    = STAT_OOM;
				rsp.free_left = count_q;
			end else begin
				rsp.status      = STAT_OK;
				rsp.got_index   = head_q;
				rsp.got_address = addr;
				rsp.free_left   = count_q - 9'd1;
			end
		end else if (put_range) begin
			rsp.status    = STAT_RANGE;
			rsp.free_left = count_q;
		end else if (put_full) begin
			rsp.status    = STAT_FULL;
			rsp.free_left = n_cur;
		end else begin
			rsp.status    = STAT_OK;
			rsp.free_left = count_q + 9'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_blocks_q   <= NUM_BLOCKS_RST;
			base_address_q <= BASE_ADDRESS_RST;
			block_words_q  <= BLOCK_WORDS_RST;
			head_q         <= 8'd0;
			count_q        <= 9'(LIM);
			vld_q          <= '0;
		end else if (cfg_hit) begin
			// any register write rebuilds the free list
			if (cfg_index == CFG_NUM_BLOCKS) begin
				num_blocks_q <= cfg_wdata[8:0];
			end
			if (cfg_index == CFG_BASE_ADDRESS) begin
				base_address_q <= cfg_wdata;
			end
			if (cfg_index == CFG_BLOCK_WORDS) begin
				block_words_q <= cfg_wdata[14:0];
			end
			head_q  <= 8'd0;
			count_q <= clamp_size(nb_next, LIM);
			vld_q   <= '0;
		end else begin
			if (cmd.accept) begin
				count_q <= rsp.free_left;
				if (put_ok) begin
					head_q        <= in_data.ret_index;
					vld_q[ridx_a] <= 1'b1;
				end
			end
			if (cmd.pop) begin
				head_q <= link_rd_q;
			end
		end
	end

	// link memory, unwritten entries read as their successor index
	always_ff @(posedge clk) begin
		if (cmd.accept && put_ok) begin
			link_mem[ridx_a] <= head_q;
		end
		if (cmd.accept) begin
			link_rd_q <= vld_q[head_a] ? link_mem[head_a] : 8'(9'(head_a) + 9'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pend_q <= rsp;
		end
		if (cmd.load_out) begin
			out_q <= pend_q;
		end
	end

	assign out_data = out_q;

endmodule
`default_nettype wire

>>> rtl/core/fixed_block_pool_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator: equal-size block pool with a LIFO free list
// A request on the in channel either takes a block (get) or gives one back
// (put); every request yields exactly one response on the out channel with
// a status, the block index and byte address on a successful get, and the
// number of free blocks left. Both channels use valid/ready transfers.
// The configuration port writes num_blocks, base_address and block_words;
// each write rebuilds the free list with blocks 0..n-1 in order. Write only
// while no request is in flight.
// A response goes to the pending slot at its request transfer and then to
// the output register. A put does not hold off the next request; after a
// get the block takes no request while the registered read of the link
// memory supplies the next list head. A response that the receiver stalls
// waits in the output register while one more request is taken and held in
// a pending slot; further requests wait until the output frees up.
// Reset is asynchronous and restores the register defaults and a full free
// list at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
	parameter int POOL_DEPTH = fbpa_pkg::POOL_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire fbpa_pkg::req_t                  in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output fbpa_pkg::rsp_t                       out_data,
	input  wire logic                            cfg_we,
	input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import fbpa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	fbpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fbpa_dp #(
		.POOL_DEPTH (POOL_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
`default_nettype wire

>>> test/tb_fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator: self-checking bench for the block pool
// A free-list tracker mirrors the pool on every request transfer: it pops
// and pushes block indexes, computes byte addresses and free counts, and
// queues the reply each request should get. Replies are checked in order
// as they leave the block. Directed requests cover empty and full pools,
// out-of-range returns, duplicate returns, size clamping and address
// wrap; random phases then run under many register settings with random
// gaps on the request side and random stalls on the reply side.
// ----------------------------------------------------------------------------
import fbpa_pkg::*;

class free_list_tracker;
	localparam int DEPTH = POOL_DEPTH_DEF;

	logic [7:0]  link [DEPTH];
	logic [7:0]  head;
	logic [8:0]  free_cnt;
	logic [8:0]  nb_reg;
	logic [31:0] base_reg;
	logic [14:0] words_reg;
	rsp_t        reply_q [$];
	logic [7:0]  taken_q [$];
	int          bad_replies;
	int          replies_seen;
	int          n_handed;
	int          n_returned;
	int          n_oom;
	int          n_full;
	int          n_range;
	int          n_settings;

	function new();
		nb_reg = NUM_BLOCKS_RST;
		base_reg = BASE_ADDRESS_RST;
		words_reg = BLOCK_WORDS_RST;
		bad_replies = 0;
		replies_seen = 0;
		n_handed = 0;
		n_returned = 0;
		n_oom = 0;
		n_full = 0;
		n_range = 0;
		n_settings = 1;
		rebuild();
	endfunction

	function int pool_n();
		int lim;
		int n;
		lim = (DEPTH < 256) ? DEPTH : 256;
		n = nb_reg;
		if (n < 1) begin
			n = 1;
		end
		if (n > lim) begin
			n = lim;
		end
		return n;
	endfunction

	function void rebuild();
		for (int i = 0; i < DEPTH; i++) begin
			link[i] = 8'(i + 1);
		end
		head = 8'd0;
		free_cnt = 9'(pool_n());
		taken_q.delete();
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_NUM_BLOCKS: begin
				nb_reg = data[8:0];
			end
			CFG_BASE_ADDRESS: begin
				base_reg = data;
			end
			CFG_BLOCK_WORDS: begin
				words_reg = data[14:0];
			end
			default: begin
				return;
			end
		endcase
		n_settings++;
		rebuild();
	endfunction

	function void note_request(req_t r);
		rsp_t        e;
		int          n;
		logic [31:0] w;
		n = pool_n();
		e = '0;
		if (r.req_type == REQ_GET) begin
			if (free_cnt == 9'd0) begin
				e.status = STAT_OOM;
				n_oom++;
			end else begin
				w = (words_reg == 15'd0) ? 32'd1 : 32'(words_reg);
				e.status = STAT_OK;
				e.got_index = head;
				e.got_address = base_reg + 32'(head) * w * 32'd4;
				taken_q.push_back(head);
				head = link[head];
				free_cnt = free_cnt - 9'd1;
				n_handed++;
			end
		end else begin
			if (int'(r.ret_index) >= n) begin
				e.status = STAT_RANGE;
				n_range++;
			end else if (int'(free_cnt) >= n) begin
				e.status = STAT_FULL;
				free_cnt = 9'(n);
				n_full++;
			end else begin
				e.status = STAT_OK;
				link[r.ret_index] = head;
				head = r.ret_index;
				free_cnt = free_cnt + 9'd1;
				n_returned++;
			end
		end
		e.free_left = free_cnt;
		reply_q.push_back(e);
	endfunction

	function void check_reply(rsp_t a);
		rsp_t e;
		logic bad;
		replies_seen++;
		if (reply_q.size() == 0) begin
			bad_replies++;
			if (bad_replies <= 10) begin
				$display("reply %0d with nothing outstanding: status=%0d idx=%0d addr=%h free=%0d",
					replies_seen, a.status, a.got_index, a.got_address, a.free_left);
			end
			return;
		end
		e = reply_q.pop_front();
		bad = (a.status !== e.status) || (a.got_index !== e.got_index) ||
			(a.got_address !== e.got_address) || (a.free_left !== e.free_left);
		if (bad) begin
			bad_replies++;
			if (bad_replies <= 10) begin
				$display("reply %0d: expected status=%0d idx=%0d addr=%h free=%0d",
					replies_seen, e.status, e.got_index, e.got_address, e.free_left);
				$display("reply %0d:      got status=%0d idx=%0d addr=%h free=%0d",
					replies_seen, a.status, a.got_index, a.got_address, a.free_left);
			end
		end
	endfunction

	function int pending();
		return reply_q.size();
	endfunction
endclass

module tb_fixed_block_pool_allocator;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_PHASES = 8;
	localparam int RANDOM_PER_PHASE = 178;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	req_t                  in_data;
	logic                  out_valid;
	logic                  out_ready;
	rsp_t                  out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	free_list_tracker sb;
	int               idle_cycles = 0;
	int               stall_left = 0;
	bit               quiet_in = 0;
	bit               quiet_out = 0;

	fixed_block_pool_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else if (!quiet_out && $urandom_range(0, 99) < 30) begin
			out_ready <= 1'b0;
			stall_left = gap_len();
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_reply(out_data);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("no transfer for %0d cycles, %0d replies outstanding",
					idle_cycles, sb.pending());
				$display("fixed_block_pool_allocator: mismatch");
				$finish;
			end
		end
	end

	function automatic req_t mk_req(logic kind, logic [7:0] idx);
		req_t r;
		r.req_type = kind;
		r.ret_index = idx;
		return r;
	endfunction

	function automatic req_t random_req(int get_pct);
		req_t r;
		int   pick;
		int   j;
		r.req_type = REQ_PUT;
		r.ret_index = 8'($urandom);
		if ($urandom_range(0, 99) < get_pct) begin
			r.req_type = REQ_GET;
			return r;
		end
		pick = $urandom_range(0, 99);
		if (sb.taken_q.size() > 0 && pick < 75) begin
			j = $urandom_range(0, sb.taken_q.size() - 1);
			r.ret_index = sb.taken_q[j];
			sb.taken_q.delete(j);
		end else if (pick < 90) begin
			r.ret_index = 8'($urandom_range(0, sb.pool_n() - 1));
		end
		return r;
	endfunction

	// called at a falling edge, returns at a falling edge after the transfer
	task automatic send_req(req_t r);
		int g;
		g = quiet_in ? 0 : gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(r);
		@(negedge clk);
	endtask

	task automatic do_get();
		send_req(mk_req(REQ_GET, 8'($urandom)));
	endtask

	task automatic do_put(logic [7:0] idx);
		send_req(mk_req(REQ_PUT, idx));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(logic [8:0] nb, logic [31:0] base, logic [14:0] words);
		wait_idle();
		write_reg(CFG_BASE_ADDRESS, base);
		write_reg(CFG_BLOCK_WORDS, {17'($urandom_range(0, 131071)), words});
		if ($urandom_range(0, 3) == 0) begin
			write_reg(CFG_UNUSED, $urandom);
		end
		write_reg(CFG_NUM_BLOCKS, {23'($urandom_range(0, 8388607)), nb});
	endtask

	function automatic logic [8:0] pick_blocks();
		case ($urandom_range(0, 6))
			0: return 9'($urandom_range(1, 4));
			1: return 9'($urandom_range(5, 16));
			2: return 9'($urandom_range(17, 255));
			3: return 9'd256;
			4: return 9'($urandom_range(257, 511));
			5: return 9'd0;
			default: return 9'($urandom_range(2, 40));
		endcase
	endfunction

	function automatic logic [31:0] pick_base();
		case ($urandom_range(0, 3))
			0: return 32'd0;
			1: return 32'hffff_ffff - 32'($urandom_range(0, 4095));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [14:0] pick_words();
		case ($urandom_range(0, 5))
			0: return 15'd0;
			1: return 15'd1;
			2: return 15'h7fff;
			3: return 15'($urandom_range(2, 64));
			default: return 15'($urandom);
		endcase
	endfunction

	initial begin
		int get_pct;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: full pool of 256
		do_get();
		do_put(8'd0);
		do_put(8'd5);
		do_put(8'd255);
		do_get();

		// three blocks, address wraps past the top
		configure(9'd3, 32'hffff_fff0, 15'h7fff);
		do_get();
		do_get();
		do_get();
		do_get();
		do_put(8'd3);
		do_put(8'd255);
		do_put(8'd1);
		do_put(8'd1);
		do_put(8'd2);
		do_put(8'd0);
		do_get();
		do_get();
		do_get();

		// zero pool size and zero block size
		configure(9'd0, 32'h0000_1000, 15'd0);
		do_get();
		do_get();
		do_put(8'd1);
		do_put(8'd0);
		do_put(8'd0);

		get_pct = 50;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0) begin
				configure(9'd511, 32'hffff_ffff, 15'd16384);
			end else begin
				configure(pick_blocks(), pick_base(), pick_words());
			end
			for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
				if (k % 40 == 0) begin
					case ($urandom_range(0, 2))
						0: get_pct = 20;
						1: get_pct = 50;
						default: get_pct = 85;
					endcase
					quiet_in = ($urandom_range(0, 3) == 0);
					quiet_out = ($urandom_range(0, 3) == 0);
				end
				send_req(random_req(get_pct));
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		$display("%0d register settings; %0d replies checked, %0d with errors",
			sb.n_settings, sb.replies_seen, sb.bad_replies);
		$display("blocks handed out %0d, returned %0d; out of memory %0d, full %0d, out of range %0d",
			sb.n_handed, sb.n_returned, sb.n_oom, sb.n_full, sb.n_range);
		if (sb.bad_replies == 0 && sb.pending() == 0) begin
			$display("fixed_block_pool_allocator: match");
		end else begin
			$display("fixed_block_pool_allocator: mismatch");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/fbpa_pkg.sv
rtl/core/fbpa_ctrl.sv
rtl/core/fbpa_dp.sv
rtl/core/fixed_block_pool_allocator.sv
test/tb_fixed_block_pool_allocator.sv
